// ===== hdl/lfm_pkg.sv =====
// Package for the line fault monitor: word layouts, register indexes and
// event codes shared by the sequencer top level and the shared divider.
// No dependencies.
package lfm_pkg;

  // Reading and mean width (converter resolution)
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned MEAN_W   = 10;
  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned IVAL_W   = 16;
  localparam int unsigned TIME_W   = 32;

  // Defaults for the top-level parameters
  localparam int unsigned BROKEN_WINDOW_DEF     = 16;
  localparam int unsigned MAX_SHORT_SAMPLES_DEF = 4095;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BROKEN_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEVEL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_LOW_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS     = 2'd3;

  localparam logic [LEVEL_W-1:0] BROKEN_LEVEL_RST    = 10'd512;
  localparam logic [LEVEL_W-1:0] SHORT_LEVEL_RST     = 10'd600;
  localparam logic [LEVEL_W-1:0] CLEAR_LOW_LEVEL_RST = 10'd100;
  localparam logic [IVAL_W-1:0]  INTERVAL_MS_RST     = 16'd1000;

  // Event and command codes
  localparam logic [1:0] EV1_NONE     = 2'd0;
  localparam logic [1:0] EV1_BROKEN   = 2'd1;
  localparam logic [1:0] EV1_RESTORED = 2'd2;

  localparam logic [2:0] LED_NONE   = 3'd0;
  localparam logic [2:0] LED_ORANGE = 3'd1;
  localparam logic [2:0] LED_GREEN  = 3'd2;
  localparam logic [2:0] LED_RED    = 3'd3;

  localparam logic [1:0] PWR_NONE = 2'd0;
  localparam logic [1:0] PWR_ON   = 2'd1;
  localparam logic [1:0] PWR_OFF  = 2'd2;

  localparam logic [1:0] SHT_NONE     = 2'd0;
  localparam logic [1:0] SHT_DETECTED = 2'd1;
  localparam logic [1:0] SHT_CLEARED  = 2'd2;

  localparam logic [1:0] REC_NONE  = 2'd0;
  localparam logic [1:0] REC_START = 2'd1;
  localparam logic [1:0] REC_STOP  = 2'd2;

  // Input word, first field in the lowest bits, padded to 7 bytes
  typedef struct packed {
    logic [1:0]          pad;
    logic                automatic_mode;
    logic [TIME_W-1:0]   now_ms;
    logic                l2_level;
    logic [SAMPLE_W-1:0] l3_sample;
    logic [SAMPLE_W-1:0] l1_sample;
  } lfm_in_t;

  // Result word, first field in the lowest bits, exactly 3 bytes
  typedef struct packed {
    logic              l3_mean_valid;
    logic [MEAN_W-1:0] l3_mean;
    logic              reactivation_pending;
    logic [1:0]        recloser_cmd;
    logic [1:0]        shortcut_event;
    logic [1:0]        power_event;
    logic [2:0]        led_cmd;
    logic              push_breaker;
    logic [1:0]        l1_event;
  } lfm_result_t;

  localparam int unsigned IN_W  = $bits(lfm_in_t);
  localparam int unsigned OUT_W = $bits(lfm_result_t);

endpackage

// ===== hdl/lfm_div.sv =====
// Shared restoring divider of the line fault monitor: one quotient bit per
// cycle, quotient known to stay below 2**MEAN_W. Depends on lfm_pkg.
module lfm_div import lfm_pkg::*; #(
  parameter int unsigned SUM_W = 22,
  parameter int unsigned DEN_W = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [MEAN_W-1:0] quot_o
);

  localparam int unsigned CMP_W  = (SUM_W > DEN_W + MEAN_W) ? SUM_W : DEN_W + MEAN_W;
  localparam int unsigned STEP_W = $clog2(MEAN_W + 1);

  logic [CMP_W-1:0]  rem_q, rem_d, den_q, den_d;
  logic [MEAN_W-1:0] quot_q, quot_d;
  logic              zero_q, zero_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic              fits;

  assign fits = (rem_q >= den_q);

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    zero_d = zero_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = CMP_W'(dividend_i);
      den_d  = CMP_W'(divisor_i) << (MEAN_W - 1);
      quot_d = '0;
      zero_d = (divisor_i == '0);
      step_d = STEP_W'(MEAN_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // trial subtract of the aligned divisor, then move it down one place
      if (fits) begin
        rem_d = rem_q - den_q;
      end
      quot_d = {quot_q[MEAN_W-2:0], fits};
      den_d  = den_q >> 1;
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    zero_q <= zero_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : quot_q;

endmodule

// ===== hdl/line_fault_monitor.sv =====
// Line fault monitor top level: handshake, state sequencer, check state and
// configuration registers. Depends on lfm_pkg and lfm_div.
//
// Channel     Direction  Handshake                       Payload
// s_axis      in         s_axis_tvalid_i/s_axis_tready_o one reading word, 56 bits
// m_axis      out        m_axis_tvalid_o/m_axis_tready_i one result word, 24 bits
// cfg         in         cfg_we_i (no back-pressure)     register index, 16-bit data
//
// A word passes the broken-cable, power, short and output steps, plus a wait
// for each division it needs: one when a line-1 window closes and one when
// a short-check interval ends. The next word is accepted only once the
// sequencer is back in its idle step. The shared divider works one quotient
// bit per cycle.
// Reset is asynchronous and active low; it loads the register defaults and
// clears all check state. The output register holds a finished result while
// the next word is accepted and worked on; the sequencer waits in its final
// step only if that register is still occupied.
module line_fault_monitor import lfm_pkg::*; #(
  parameter int unsigned BROKEN_WINDOW     = BROKEN_WINDOW_DEF,
  parameter int unsigned MAX_SHORT_SAMPLES = MAX_SHORT_SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // l1_sample[9:0], l3_sample[19:10], l2_level[20], now_ms[52:21],
  // automatic_mode[53], zero fill[55:54]
  input  logic [IN_W-1:0]       s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // l1_event[1:0], push_breaker[2], led_cmd[5:3], power_event[7:6],
  // shortcut_event[9:8], recloser_cmd[11:10], reactivation_pending[12],
  // l3_mean[22:13], l3_mean_valid[23]
  output logic [OUT_W-1:0]      m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Storage widths follow from the window and the sample cap
  localparam int unsigned L1C_W = $clog2(BROKEN_WINDOW + 1);
  localparam int unsigned L1S_W = L1C_W + SAMPLE_W;
  localparam int unsigned L3C_W = $clog2(MAX_SHORT_SAMPLES + 1);
  localparam int unsigned L3S_W = L3C_W + SAMPLE_W;
  localparam int unsigned SUM_W = (L1S_W > L3S_W) ? L1S_W : L3S_W;
  localparam int unsigned DEN_W = (L1C_W > L3C_W) ? L1C_W : L3C_W;

  // Sequencer steps
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BRK   = 3'd1;
  localparam logic [2:0] ST_BRK_W = 3'd2;
  localparam logic [2:0] ST_PWR   = 3'd3;
  localparam logic [2:0] ST_SHT   = 3'd4;
  localparam logic [2:0] ST_SHT_W = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]         state_q, state_d;

  logic [LEVEL_W-1:0] broken_level_q, broken_level_d;
  logic [LEVEL_W-1:0] short_level_q, short_level_d;
  logic [LEVEL_W-1:0] clear_low_q, clear_low_d;
  logic [IVAL_W-1:0]  interval_q, interval_d;

  logic [L1S_W-1:0]   l1_sum_q, l1_sum_d, l1_sum_nx;
  logic [L1C_W-1:0]   l1_count_q, l1_count_d, l1_count_nx;
  logic               cable_broken_q, cable_broken_d;
  logic               power_on_q, power_on_d;
  logic [TIME_W-1:0]  last_pwr_q, last_pwr_d;
  logic [L3S_W-1:0]   l3_sum_q, l3_sum_d, l3_sum_nx;
  logic [L3C_W-1:0]   l3_count_q, l3_count_d, l3_count_nx;
  logic               short_seen_q, short_seen_d;
  logic [TIME_W-1:0]  last_sht_q, last_sht_d;
  logic               react_q, react_d;

  lfm_in_t            in_q, in_d;
  lfm_result_t        res_q, res_d;
  lfm_result_t        out_q, out_d;
  logic               m_valid_q, m_valid_d;

  logic [TIME_W-1:0]  last_sel, elapsed;
  logic               over;

  logic               div_start, div_busy, div_done;
  logic [SUM_W-1:0]   div_dividend;
  logic [DEN_W-1:0]   div_divisor;
  logic [MEAN_W-1:0]  div_quot;

  lfm_div #(
    .SUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // One elapsed-time compare, shared by the power and the short step.
  // The subtract wraps modulo 2**32 on purpose.
  assign last_sel = (state_q == ST_PWR) ? last_pwr_q : last_sht_q;
  assign elapsed  = in_q.now_ms - last_sel;
  assign over     = (elapsed > TIME_W'(interval_q));

  // Running sums for this word
  assign l1_sum_nx   = l1_sum_q + L1S_W'(in_q.l1_sample);
  assign l1_count_nx = l1_count_q + 1'b1;
  always_comb begin
    if (l3_count_q < L3C_W'(MAX_SHORT_SAMPLES)) begin
      l3_sum_nx   = l3_sum_q + L3S_W'(in_q.l3_sample);
      l3_count_nx = l3_count_q + 1'b1;
    end else begin
      // cap reached: drop further samples of this interval
      l3_sum_nx   = l3_sum_q;
      l3_count_nx = l3_count_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    broken_level_d = broken_level_q;
    short_level_d  = short_level_q;
    clear_low_d    = clear_low_q;
    interval_d     = interval_q;
    l1_sum_d       = l1_sum_q;
    l1_count_d     = l1_count_q;
    cable_broken_d = cable_broken_q;
    power_on_d     = power_on_q;
    last_pwr_d     = last_pwr_q;
    l3_sum_d       = l3_sum_q;
    l3_count_d     = l3_count_q;
    short_seen_d   = short_seen_q;
    last_sht_d     = last_sht_q;
    react_d        = react_q;
    in_d           = in_q;
    res_d          = res_q;
    out_d          = out_q;
    m_valid_d      = m_valid_q;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;

    // Configuration writes, width-truncated; the host must write only while idle (not enforced here)
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BROKEN_LEVEL:    broken_level_d = cfg_data_i[LEVEL_W-1:0];
        CFG_SHORT_LEVEL:     short_level_d  = cfg_data_i[LEVEL_W-1:0];
        CFG_CLEAR_LOW_LEVEL: clear_low_d    = cfg_data_i[LEVEL_W-1:0];
        CFG_INTERVAL_MS:     interval_d     = cfg_data_i[IVAL_W-1:0];
        default: ;
      endcase
    end

    // Free the output register once the word is taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          in_d    = s_axis_tdata_i;
          res_d   = '0;
          state_d = ST_BRK;
        end
      end

      // Broken-cable check: accumulate line 1 while powered and not shorted
      ST_BRK: begin
        state_d = ST_PWR;
        if (power_on_q && !short_seen_q) begin
          if (l1_count_nx == L1C_W'(BROKEN_WINDOW)) begin
            // window closes: hand the sum to the divider, restart the window
            div_start    = 1'b1;
            div_dividend = SUM_W'(l1_sum_nx);
            div_divisor  = DEN_W'(BROKEN_WINDOW);
            l1_sum_d     = '0;
            l1_count_d   = '0;
            state_d      = ST_BRK_W;
          end else begin
            l1_sum_d   = l1_sum_nx;
            l1_count_d = l1_count_nx;
          end
        end
      end

      ST_BRK_W: begin
        if (div_done) begin
          if (div_quot < broken_level_q) begin
            if (!cable_broken_q) begin
              cable_broken_d = 1'b1;
              res_d.l1_event = EV1_BROKEN;
              if (in_q.automatic_mode) begin
                res_d.push_breaker = 1'b1;
              end else begin
                res_d.led_cmd = LED_ORANGE;
              end
            end
          end else if (cable_broken_q) begin
            cable_broken_d = 1'b0;
            res_d.l1_event = EV1_RESTORED;
            if (!in_q.automatic_mode) begin
              res_d.led_cmd = LED_GREEN;
            end
          end
          state_d = ST_PWR;
        end
      end

      // Power check on interval end: follow edges of the line-2 level
      ST_PWR: begin
        if (over) begin
          if (in_q.l2_level && !power_on_q) begin
            power_on_d        = 1'b1;
            res_d.led_cmd     = LED_GREEN;
            res_d.power_event = PWR_ON;
          end else if (!in_q.l2_level && power_on_q) begin
            power_on_d        = 1'b0;
            res_d.led_cmd     = LED_RED;
            res_d.power_event = PWR_OFF;
          end
          last_pwr_d = in_q.now_ms;
        end
        state_d = ST_SHT;
      end

      // Short check: accumulate line 3, divide at interval end
      ST_SHT: begin
        if (over) begin
          div_start    = 1'b1;
          div_dividend = SUM_W'(l3_sum_nx);
          div_divisor  = DEN_W'(l3_count_nx);
          l3_sum_d     = '0;
          l3_count_d   = '0;
          last_sht_d   = in_q.now_ms;
          state_d      = ST_SHT_W;
        end else begin
          l3_sum_d   = l3_sum_nx;
          l3_count_d = l3_count_nx;
          state_d    = ST_OUT;
        end
      end

      ST_SHT_W: begin
        if (div_done) begin
          res_d.l3_mean       = div_quot;
          res_d.l3_mean_valid = 1'b1;
          if (div_quot > short_level_q && !short_seen_q) begin
            if (in_q.automatic_mode) begin
              res_d.recloser_cmd = REC_START;
            end
            short_seen_d         = 1'b1;
            res_d.shortcut_event = SHT_DETECTED;
          end else if (div_quot < short_level_q && div_quot > clear_low_q &&
                       short_seen_q) begin
            res_d.recloser_cmd   = REC_STOP;
            short_seen_d         = 1'b0;
            react_d              = 1'b1;
            res_d.shortcut_event = SHT_CLEARED;
          end
          state_d = ST_OUT;
        end
      end

      // Hand the result to the output register when it is free
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_d                      = res_q;
          out_d.reactivation_pending = react_q;
          m_valid_d                  = 1'b1;
          state_d                    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      broken_level_q <= BROKEN_LEVEL_RST;
      short_level_q  <= SHORT_LEVEL_RST;
      clear_low_q    <= CLEAR_LOW_LEVEL_RST;
      interval_q     <= INTERVAL_MS_RST;
      l1_sum_q       <= '0;
      l1_count_q     <= '0;
      cable_broken_q <= 1'b0;
      power_on_q     <= 1'b0;
      last_pwr_q     <= '0;
      l3_sum_q       <= '0;
      l3_count_q     <= '0;
      short_seen_q   <= 1'b0;
      last_sht_q     <= '0;
      react_q        <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      broken_level_q <= broken_level_d;
      short_level_q  <= short_level_d;
      clear_low_q    <= clear_low_d;
      interval_q     <= interval_d;
      l1_sum_q       <= l1_sum_d;
      l1_count_q     <= l1_count_d;
      cable_broken_q <= cable_broken_d;
      power_on_q     <= power_on_d;
      last_pwr_q     <= last_pwr_d;
      l3_sum_q       <= l3_sum_d;
      l3_count_q     <= l3_count_d;
      short_seen_q   <= short_seen_d;
      last_sht_q     <= last_sht_d;
      react_q        <= react_d;
      m_valid_q      <= m_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  // The divider runs only while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_BRK_W || state_q == ST_SHT_W))
    else $error("divider busy outside a wait step");

  // The line-1 window closes before its count reaches the window size
  a_l1_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l1_count_q < L1C_W'(BROKEN_WINDOW))
    else $error("line-1 window count overrun");

  // The line-3 count never passes its cap
  a_l3_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l3_count_q <= L3C_W'(MAX_SHORT_SAMPLES))
    else $error("line-3 sample count above cap");

  // A result without an interval end carries a zero mean
  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !out_q.l3_mean_valid) |-> (out_q.l3_mean == '0))
    else $error("mean set without interval end");
`endif

endmodule
